// File: rtl/maximal_munch_tokenizer_top_macros.svh
// ----------------------------------------------------------------------------
// maximal_munch_tokenizer_top_macros
// Assertion macros shared by the tokenizer's checker.
// ----------------------------------------------------------------------------
`ifndef MAXIMAL_MUNCH_TOKENIZER_TOP_MACROS_SVH
`define MAXIMAL_MUNCH_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MMT_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tokenizer check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define MMT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tokenizer check failed: next-cycle rule");

`endif

// File: rtl/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg
// Token record, kind and character codes, and character-class functions.
// ----------------------------------------------------------------------------
package mmt_pkg;

   localparam int FIELD_BITS = 24;
   localparam int VALUE_BITS = 63;

   localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOF  = 1'b1;

   localparam logic [1:0] KIND_IDENT   = 2'd0;
   localparam logic [1:0] KIND_INTEGER = 2'd1;
   localparam logic [1:0] KIND_PUNCT   = 2'd2;
   localparam logic [1:0] KIND_EOF     = 2'd3;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_BAR     = 8'h7C;

   typedef struct packed {
      logic [1:0]            kind;
      logic [FIELD_BITS-1:0] start_offset;
      logic [FIELD_BITS-1:0] length;
      logic [VALUE_BITS-1:0] number;
      logic [7:0]            punct_first;
      logic [7:0]            punct_second;
      logic [FIELD_BITS-1:0] line_number;
      logic                  last;
   } token_type;

   // Up to two tokens produced by one item, in order.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } tok_pair_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   function automatic logic is_op_pair(input logic [7:0] a, input logic [7:0] b);
      logic r;
      case ({a, b})
         {CH_MINUS, CH_GT}, {CH_DOT, CH_DOT}, {CH_LT, CH_LT}, {CH_GT, CH_GT},
         {CH_LT, CH_EQ}, {CH_GT, CH_EQ}, {CH_EQ, CH_EQ}, {CH_BANG, CH_EQ},
         {CH_AMP, CH_AMP}, {CH_BAR, CH_BAR}: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/mmt_lexer_core.sv
// ----------------------------------------------------------------------------
// mmt_lexer_core
// Scanner state and the per-byte token decision, one byte per fire.
// ----------------------------------------------------------------------------
module mmt_lexer_core import mmt_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic         op,
   input  logic [7:0]   ch,
   output tok_pair_type push
);

   localparam int SAT_W = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_PUNCT,
      MODE_LINE_CMT, MODE_BLOCK, MODE_BLOCK_STAR
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [7:0]             held_ff, held_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [FIELD_BITS-1:0]  tline_ff, tline_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [FIELD_BITS-1:0]  cline_ff, cline_in;

   logic                   start_new;
   logic                   flush_valid;
   token_type              flush_tok;
   token_type              eof_tok;
   logic [OFFSET_BITS-1:0] tok_len;
   logic [VALUE_BITS+3:0]  value_x10;
   logic [FIELD_BITS-1:0]  cline_inc;
   tok_pair_type           push_c;

   function automatic logic [FIELD_BITS-1:0] sat_field(input logic [OFFSET_BITS-1:0] v);
      logic [SAT_W-1:0] ext;
      ext = SAT_W'(v);
      return (ext > SAT_W'(FIELD_MAX)) ? FIELD_MAX : ext[FIELD_BITS-1:0];
   endfunction

   assign tok_len   = offset_ff - start_ff;
   assign cline_inc = (cline_ff != FIELD_MAX) ? cline_ff + 1'b1 : cline_ff;
   assign value_x10 = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1)
                    + (VALUE_BITS+4)'(ch[3:0] - CH_0[3:0]);

   always_comb begin
      flush_tok              = '0;
      flush_tok.start_offset = sat_field(start_ff);
      flush_tok.line_number  = tline_ff;
      flush_tok.length       = sat_field(tok_len);
      flush_valid            = 1'b1;
      case (mode_ff)
         MODE_IDENT: flush_tok.kind = KIND_IDENT;
         MODE_NUMBER: begin
            flush_tok.kind   = KIND_INTEGER;
            flush_tok.number = value_ff;
         end
         MODE_PUNCT: begin
            flush_tok.kind        = KIND_PUNCT;
            flush_tok.length      = FIELD_BITS'(1);
            flush_tok.punct_first = held_ff;
         end
         default: flush_valid = 1'b0;
      endcase

      eof_tok              = '0;
      eof_tok.kind         = KIND_EOF;
      eof_tok.start_offset = sat_field(offset_ff);
      eof_tok.line_number  = cline_ff;
      eof_tok.last         = 1'b1;
   end

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      start_in  = start_ff;
      tline_in  = tline_ff;
      value_in  = value_ff;
      offset_in = offset_ff;
      cline_in  = cline_ff;
      start_new = 1'b0;
      push_c    = '0;

      if (op == OP_EOF) begin
         if (flush_valid) begin
            push_c.count  = 2'd2;
            push_c.first  = flush_tok;
            push_c.second = eof_tok;
         end else begin
            push_c.count = 2'd1;
            push_c.first = eof_tok;
         end
         mode_in   = MODE_IDLE;
         held_in   = '0;
         start_in  = '0;
         tline_in  = FIELD_BITS'(1);
         value_in  = '0;
         offset_in = '0;
         cline_in  = FIELD_BITS'(1);
      end else begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (!is_word(ch)) begin
                  push_c.count = 2'd1;
                  push_c.first = flush_tok;
                  start_new    = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(ch)) begin
                  value_in = (value_x10 > (VALUE_BITS+4)'(VALUE_MAX)) ? VALUE_MAX
                                                                     : value_x10[VALUE_BITS-1:0];
               end else begin
                  push_c.count = 2'd1;
                  push_c.first = flush_tok;
                  start_new    = 1'b1;
               end
            end
            MODE_PUNCT: begin
               if (held_ff == CH_SLASH && ch == CH_SLASH) begin
                  mode_in = MODE_LINE_CMT;
               end else if (held_ff == CH_SLASH && ch == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else if (is_op_pair(held_ff, ch)) begin
                  push_c.count              = 2'd1;
                  push_c.first              = flush_tok;
                  push_c.first.length       = FIELD_BITS'(2);
                  push_c.first.punct_second = ch;
                  mode_in                   = MODE_IDLE;
               end else begin
                  push_c.count = 2'd1;
                  push_c.first = flush_tok;
                  start_new    = 1'b1;
               end
            end
            MODE_LINE_CMT: begin
               if (ch == CH_NL) begin
                  cline_in = cline_inc;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_BLOCK, MODE_BLOCK_STAR: begin
               if (ch == CH_NL) begin
                  cline_in = cline_inc;
               end
               if (mode_ff == MODE_BLOCK_STAR && ch == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in = (ch == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
               end
            end
            default: start_new = 1'b1;
         endcase

         // A byte that ends the previous token may itself open a new one.
         if (start_new) begin
            mode_in = MODE_IDLE;
            if (ch == CH_NL) begin
               cline_in = cline_inc;
            end else if (!is_space(ch)) begin
               start_in = offset_ff;
               tline_in = cline_ff;
               if (is_alpha(ch) || ch == CH_UNDER) begin
                  mode_in = MODE_IDENT;
               end else if (is_digit(ch)) begin
                  mode_in  = MODE_NUMBER;
                  value_in = VALUE_BITS'(ch[3:0] - CH_0[3:0]);
               end else begin
                  mode_in = MODE_PUNCT;
                  held_in = ch;
               end
            end
         end

         if (offset_ff != OFFSET_MAX) begin
            offset_in = offset_ff + 1'b1;
         end
         push_c.first.last = 1'b1;
      end
   end

   assign push = fire ? push_c : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         held_ff   <= '0;
         start_ff  <= '0;
         tline_ff  <= FIELD_BITS'(1);
         value_ff  <= '0;
         offset_ff <= '0;
         cline_ff  <= FIELD_BITS'(1);
      end else if (fire) begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         start_ff  <= start_in;
         tline_ff  <= tline_in;
         value_ff  <= value_in;
         offset_ff <= offset_in;
         cline_ff  <= cline_in;
      end
   end

endmodule

// File: rtl/mmt_result_fifo.sv
// ----------------------------------------------------------------------------
// mmt_result_fifo
// Small token queue that takes up to two tokens a cycle and gives one.
// ----------------------------------------------------------------------------
module mmt_result_fifo import mmt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  tok_pair_type push,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output token_type    out_tok
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_next;
   logic               pop;

   assign out_valid   = count_ff != '0;
   assign out_tok     = entry_ff[rd_ptr_ff];
   assign room        = count_ff <= CNT_W'(DEPTH - 2);
   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = PTR_W'(wr_ptr_ff + 1'b1);
   assign wr_ptr_in   = PTR_W'(wr_ptr_ff + push.count);
   assign rd_ptr_in   = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in    = CNT_W'(count_ff + CNT_W'(push.count) - CNT_W'(pop));

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/maximal_munch_tokenizer_top.sv
// ----------------------------------------------------------------------------
// maximal_munch_tokenizer_top: streaming maximal-munch tokenizer
// Throughput: one byte beat per cycle while the queue has room for two tokens;
// the scanner's combinational decision between the input register and the
// token queue sets that figure. A beat fires from the input register while
// the queue holds at most two tokens; the queue then drives rsp_valid.
// Reset: synchronous; clears the scanner to line 1, offset 0, queue empty.
// ----------------------------------------------------------------------------
module maximal_munch_tokenizer_top import mmt_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [23:0] rsp_start_offset,
   output logic [23:0] rsp_length,
   output logic [62:0] rsp_number,
   output logic [7:0]  rsp_punct_first,
   output logic [7:0]  rsp_punct_second,
   output logic [23:0] rsp_line_number,
   output logic        rsp_last
);

   // Input register. A byte beat sits here while the scanner decides on it;
   // it moves on as soon as the queue has room for two tokens,
   // which is enough for the flush and eof pair of an end-of-text beat.
   logic         in_valid_ff, in_valid_in;
   logic         in_op_ff;
   logic [7:0]   in_ch_ff;
   logic         fire;
   logic         room;
   tok_pair_type push;
   token_type    out_tok;

   assign fire        = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // The payload needs no reset; it is loaded only on an accepted beat.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff <= req_op;
         in_ch_ff <= req_ch;
      end
   end

   // Scanner: holds the mode, the pending token and the counters, and turns
   // one byte into zero or one token, or end of text into one or two.
   mmt_lexer_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .op    (in_op_ff),
      .ch    (in_ch_ff),
      .push  (push)
   );

   // Token queue: decouples the scanner from a stalled consumer, so new
   // bytes keep flowing while a finished token waits to be taken.
   mmt_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_tok   (out_tok)
   );

   assign rsp_kind         = out_tok.kind;
   assign rsp_start_offset = out_tok.start_offset;
   assign rsp_length       = out_tok.length;
   assign rsp_number       = out_tok.number;
   assign rsp_punct_first  = out_tok.punct_first;
   assign rsp_punct_second = out_tok.punct_second;
   assign rsp_line_number  = out_tok.line_number;
   assign rsp_last         = out_tok.last;

endmodule

// File: rtl/mmt_checker.sv
// ----------------------------------------------------------------------------
// mmt_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
`include "maximal_munch_tokenizer_top_macros.svh"

module mmt_checker import mmt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [23:0] rsp_start_offset,
   input logic [23:0] rsp_length,
   input logic [62:0] rsp_number,
   input logic [7:0]  rsp_punct_first,
   input logic [7:0]  rsp_punct_second,
   input logic [23:0] rsp_line_number,
   input logic        rsp_last
);

   logic      rsp_eof;
   logic      rsp_stall;
   logic      punct_shape_ok;
   token_type rsp_tok;

   assign rsp_eof        = rsp_valid && rsp_kind == KIND_EOF;
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign punct_shape_ok = (rsp_length == 24'd1 && rsp_punct_second == 8'd0)
                        || rsp_length == 24'd2;
   assign rsp_tok        = {rsp_kind, rsp_start_offset, rsp_length, rsp_number,
                            rsp_punct_first, rsp_punct_second, rsp_line_number,
                            rsp_last};

   // A stalled token holds its contents.
   `MMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_tok))

   // The eof token closes its beat and has no length.
   `MMT_ASSERT_NOW(a_eof_shape, clock, reset, rsp_eof, rsp_last && rsp_length == '0)

   // Only integers carry a value.
   `MMT_ASSERT_NOW(a_number_zero, clock, reset, rsp_valid && rsp_kind != KIND_INTEGER, rsp_number == '0)

   // Punctuation is one or two bytes, and only a pair has a second byte.
   `MMT_ASSERT_NOW(a_punct_len, clock, reset, rsp_valid && rsp_kind == KIND_PUNCT, punct_shape_ok)

endmodule

bind maximal_munch_tokenizer_top mmt_checker u_mmt_checker (.*);
